// File: rtl/pqcd_pkg.sv
// Package for the priority queue with class-selective take.
// Holds the entry and link types, field widths and request codes; no dependencies.
package pqcd_pkg;

  localparam int ClassW = 4;
  localparam int PrioW  = 2;
  localparam int OccW   = 5;
  localparam int CapW   = 5;

  localparam logic [CapW-1:0] CapReset = 5'd16;

  typedef enum logic {
    MODE_ENQUEUE = 1'b0,
    MODE_TAKE    = 1'b1
  } mode_t;

  typedef struct packed {
    logic [ClassW-1:0] cls;
    logic [PrioW-1:0]  prio;
  } entry_t;

  // Carried from each cell to the one behind it.
  typedef struct packed {
    logic             lower;
    logic             hit;
    logic [PrioW-1:0] prio;
  } link_t;

  // Broadcast to every cell.
  typedef struct packed {
    logic   en;
    logic   take;
    entry_t ent;
  } op_t;

endpackage

// File: rtl/pqcd_cell.sv
// One storage cell of the ordered queue row.
// Depends on pqcd_pkg for the entry, link and operation types.
module pqcd_cell (
  input  logic             clk,
  input  logic             occupied,
  input  pqcd_pkg::op_t    op,
  input  pqcd_pkg::link_t  link_i,
  input  pqcd_pkg::entry_t left_i,
  input  pqcd_pkg::entry_t right_i,
  output pqcd_pkg::link_t  link_o,
  output pqcd_pkg::entry_t ent_o
);

  pqcd_pkg::entry_t ent_r;
  pqcd_pkg::entry_t ent_nxt;
  logic             lower_self;
  logic             match;

  always_comb begin
    lower_self  = !occupied || (ent_r.prio < op.ent.prio);
    match       = occupied && (ent_r.cls == op.ent.cls);
    link_o.lower = lower_self;
    link_o.hit   = link_i.hit || match;
    link_o.prio  = link_i.hit ? link_i.prio : (match ? ent_r.prio : '0);
    ent_nxt = ent_r;
    if (op.take) begin
      if (link_i.hit || match) begin
        ent_nxt = right_i;
      end
    end else if (lower_self) begin
      ent_nxt = link_i.lower ? left_i : op.ent;
    end
  end

  always_ff @(posedge clk) begin
    if (op.en) begin
      ent_r <= ent_nxt;
    end
  end

  assign ent_o = ent_r;

endmodule

// File: rtl/priority_queue_class_dequeue.sv
// Top level of the bounded priority queue with class-selective take.
// Depends on pqcd_pkg and instantiates a row of pqcd_cell.
//
// The queue keeps up to QUEUE_DEPTH requests ordered by priority, highest at
// the head and equal priorities in arrival order. An enqueue request inserts
// before the first entry of lower priority and is refused once occupancy
// reaches the capacity register (reset value 16, limited to QUEUE_DEPTH) or
// when its class is not below NUM_CLASSES. A take request removes the entry
// nearest the head with the given class and reports its priority. The result
// of each request is registered, and one request can be accepted per clock
// unless out_stall holds back a pending result; the path that sets this rate
// is the compare and shift across the cell row, with the first-match flag
// rippling through the cells. Reset empties the queue.
module priority_queue_class_dequeue #(
  parameter int QUEUE_DEPTH     = 16,
  parameter int NUM_CLASSES     = 16,
  parameter int PRIORITY_LEVELS = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_mode,
  input  logic [pqcd_pkg::ClassW-1:0]  in_req_class,
  input  logic [pqcd_pkg::PrioW-1:0]   in_req_priority,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_done_ok,
  output logic [pqcd_pkg::PrioW-1:0]   out_taken_priority,
  output logic [pqcd_pkg::OccW-1:0]    out_occupancy,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pqcd_pkg::CapW-1:0]    cfg_data
);

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int CmpW = (CntW > pqcd_pkg::CapW) ? CntW : pqcd_pkg::CapW;

  logic [CntW-1:0]              count_r;
  logic [CntW-1:0]              count_nxt;
  logic [pqcd_pkg::CapW-1:0]    cap_r;
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic                         out_done_ok_r;
  logic [pqcd_pkg::PrioW-1:0]   out_taken_priority_r;
  logic [pqcd_pkg::OccW-1:0]    out_occupancy_r;

  logic                         accept;
  logic                         is_take;
  logic                         class_ok;
  logic                         full;
  logic                         enq_ok;
  logic                         found;
  logic [pqcd_pkg::PrioW-1:0]   prio_sat;
  pqcd_pkg::op_t                op;
  pqcd_pkg::entry_t             ents [QUEUE_DEPTH];
  pqcd_pkg::link_t              links [QUEUE_DEPTH+1];

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    is_take  = (in_mode == pqcd_pkg::MODE_TAKE);
    class_ok = (32'(in_req_class) < NUM_CLASSES);
    prio_sat = (32'(in_req_priority) >= PRIORITY_LEVELS) ?
               pqcd_pkg::PrioW'(PRIORITY_LEVELS - 1) : in_req_priority;
    full     = (CmpW'(count_r) >= CmpW'(cap_r)) || (count_r >= CntW'(QUEUE_DEPTH));
    enq_ok   = !is_take && class_ok && !full;
    op.en       = accept && (is_take || enq_ok);
    op.take     = is_take;
    op.ent.cls  = in_req_class;
    op.ent.prio = prio_sat;
  end

  assign links[0] = '0;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    pqcd_cell u_cell (
      .clk      (clk),
      .occupied (count_r > CntW'(g)),
      .op       (op),
      .link_i   (links[g]),
      .left_i   ((g == 0) ? op.ent : ents[(g == 0) ? 0 : g - 1]),
      .right_i  ((g == QUEUE_DEPTH - 1) ? op.ent
                 : ents[(g == QUEUE_DEPTH - 1) ? g : g + 1]),
      .link_o   (links[g+1]),
      .ent_o    (ents[g])
    );
  end

  assign found = links[QUEUE_DEPTH].hit;

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      if (enq_ok) begin
        count_nxt = count_r + CntW'(1);
      end else if (is_take && found) begin
        count_nxt = count_r - CntW'(1);
      end
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cap_r       <= pqcd_pkg::CapReset;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_done_ok_r        <= is_take ? found : enq_ok;
      out_taken_priority_r <= is_take ? links[QUEUE_DEPTH].prio : '0;
      out_occupancy_r      <= pqcd_pkg::OccW'(count_nxt);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_done_ok        = out_done_ok_r;
  assign out_taken_priority = out_taken_priority_r;
  assign out_occupancy      = out_occupancy_r;

endmodule
